// ----- hdl/bvoe_pkg.sv -----
// Shared types, opcodes and helpers for the bit-vector operation evaluator.
`timescale 1ns / 1ps

package bvoe_pkg;

	// Opcode list of the command channel
	typedef enum logic [5:0] {
		OP_NOT      = 6'd0,
		OP_EXTRACT  = 6'd1,
		OP_ZEXT     = 6'd2,
		OP_SEXT     = 6'd3,
		OP_NEG      = 6'd4,
		OP_ADD      = 6'd5,
		OP_AND      = 6'd6,
		OP_CONCAT   = 6'd7,
		OP_EQUAL    = 6'd8,
		OP_XOR      = 6'd9,
		OP_OR       = 6'd10,
		OP_MUL      = 6'd11,
		OP_COMP     = 6'd12,
		OP_DISTINCT = 6'd13,
		OP_UDIV     = 6'd14,
		OP_SUB      = 6'd15,
		OP_ULT      = 6'd16,
		OP_ULE      = 6'd17,
		OP_UGT      = 6'd18,
		OP_UGE      = 6'd19,
		OP_SLT      = 6'd20,
		OP_SLE      = 6'd21,
		OP_SGT      = 6'd22,
		OP_SGE      = 6'd23,
		OP_NAND     = 6'd24,
		OP_NOR      = 6'd25,
		OP_XNOR     = 6'd26,
		OP_UREM     = 6'd27,
		OP_SDIV     = 6'd28,
		OP_SREM     = 6'd29,
		OP_LSHR     = 6'd30,
		OP_ASHR     = 6'd31,
		OP_SHL      = 6'd32,
		OP_IMPLIES  = 6'd33,
		OP_ITE      = 6'd34
	} opcode_e;

	// Which unit supplies the final value
	typedef enum logic [1:0] {
		KIND_SIMPLE = 2'd0,
		KIND_MUL    = 2'd1,
		KIND_QUO    = 2'd2,
		KIND_REM    = 2'd3
	} kind_e;

	typedef struct packed {
		logic [5:0]  operation;
		logic [63:0] operand_a;
		logic [63:0] operand_b;
		logic        condition;
		logic [6:0]  width_a;
		logic [6:0]  width_b;
		logic [5:0]  index_high;
		logic [5:0]  index_low;
	} cmd_t;

	typedef struct packed {
		logic [63:0] result_value;
		logic [6:0]  result_width;
		logic        error_flag;
	} rsp_t;

	// Sideband that travels with an item through the divider
	typedef struct packed {
		logic [63:0] value;
		logic [6:0]  width;
		logic        err;
		kind_e       kind;
		logic        neg;
	} side_t;

	localparam int DIV_STAGES = 64;
	localparam int LATENCY    = DIV_STAGES + 4;

	// Low-order mask of w ones
	function automatic logic [63:0] wmask(input logic [6:0] w);
		logic [63:0] m;
		if (w >= 7'd64) begin
			m = '1;
		end else begin
			m = (64'd1 << w[5:0]) - 64'd1;
		end
		return m;
	endfunction

endpackage

// ----- hdl/bvoe_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`timescale 1ns / 1ps

module bvoe_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  logic [63:0]        dividend,
	input  logic [63:0]        divisor,
	input  bvoe_pkg::side_t    side_in,
	output logic               out_vld,
	output logic [63:0]        quotient,
	output logic [63:0]        remainder,
	output bvoe_pkg::side_t    side_out
);

	localparam int N = bvoe_pkg::DIV_STAGES;

	logic            vld_s  [0:N];
	logic [63:0]     rem_s  [0:N];
	logic [63:0]     quo_s  [0:N];
	logic [63:0]     dvs_s  [0:N];
	bvoe_pkg::side_t side_s [0:N];

	// Feed stage zero straight from the inputs
	assign vld_s[0]  = in_vld;
	assign rem_s[0]  = '0;
	assign quo_s[0]  = dividend;
	assign dvs_s[0]  = divisor;
	assign side_s[0] = side_in;

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [64:0] trial;
		logic        ge;
		logic [64:0] diff;

		// Shift in the next dividend bit and try the subtract
		always_comb begin
			trial = {rem_s[k], quo_s[k][63]};
			ge    = trial >= {1'b0, dvs_s[k]};
			diff  = trial - {1'b0, dvs_s[k]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? diff[63:0] : trial[63:0];
			quo_s[k+1]  <= {quo_s[k][62:0], ge};
			dvs_s[k+1]  <= dvs_s[k];
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_vld   = vld_s[N];
	assign quotient  = quo_s[N];
	assign remainder = rem_s[N];
	assign side_out  = side_s[N];

endmodule

// ----- hdl/bitvector_operation_evaluator.sv -----
// Top level: pipelined SMT-LIB bit-vector operation evaluator.
`timescale 1ns / 1ps

//  channel | signals                   | transfer
//  --------+---------------------------+-------------------------------
//  command | start, busy, cmd          | edge with start high, busy low
//  result  | done, rsp                 | edge ending the done cycle
//
//  One command enters every cycle; busy stays low since nothing stalls.
//  Between a command and its result lie three front stages
//  (operand masking, operation logic and partial products, product sum),
//  64 stages of the restoring divider, and the output register.
//  Reset clears the valid bits only; results leave in command order.

module bitvector_operation_evaluator #(
	parameter int MAX_WIDTH = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  bvoe_pkg::cmd_t  cmd,
	output logic            done,
	output bvoe_pkg::rsp_t  rsp
);

	localparam logic [6:0] MAXW = 7'(MAX_WIDTH);

	assign busy = 1'b0;

	// ---------------- stage 1: clamp widths, mask operands
	logic        vld_s1;
	logic [5:0]  opc_s1;
	logic [6:0]  wa_s1, wb_s1;
	logic [63:0] a_s1, bb_s1, b_s1, m_s1;
	logic [5:0]  hi_s1, lo_s1;
	logic        cond_s1;

	logic [6:0]  wa_c, wb_c;
	logic [63:0] ma_c, mb_c;

	always_comb begin
		wa_c = (cmd.width_a == 7'd0) ? 7'd1 : (cmd.width_a > MAXW) ? MAXW : cmd.width_a;
		wb_c = (cmd.width_b == 7'd0) ? 7'd1 : (cmd.width_b > MAXW) ? MAXW : cmd.width_b;
		ma_c = bvoe_pkg::wmask(wa_c);
		mb_c = bvoe_pkg::wmask(wb_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		opc_s1  <= cmd.operation;
		wa_s1   <= wa_c;
		wb_s1   <= wb_c;
		a_s1    <= cmd.operand_a & ma_c;
		bb_s1   <= cmd.operand_b & mb_c;
		b_s1    <= cmd.operand_b & mb_c & ma_c;
		m_s1    <= ma_c;
		hi_s1   <= cmd.index_high;
		lo_s1   <= cmd.index_low;
		cond_s1 <= cmd.condition;
	end

	// ---------------- stage 2: operation logic, partial products, divider prep
	logic            vld_s2;
	bvoe_pkg::side_t side_s2;
	logic [63:0]     dvd_s2, dvs_s2;
	logic [63:0]     pp_ll_s2;
	logic [31:0]     pp_lh_s2, pp_hl_s2;

	bvoe_pkg::side_t side_c;
	logic [63:0]     dvd_c, dvs_c;

	always_comb begin
		logic [63:0] sign;
		logic        na, nb, big;
		logic [63:0] sa, sb, mag_a, mag_b;
		logic [7:0]  wsum;

		sign  = 64'd1 << (wa_s1 - 7'd1);
		na    = (a_s1 & sign) != 64'd0;
		nb    = (b_s1 & sign) != 64'd0;
		sa    = a_s1 ^ sign;
		sb    = b_s1 ^ sign;
		big   = b_s1 >= {57'd0, wa_s1};
		mag_a = (na ? 64'd0 - a_s1 : a_s1) & m_s1;
		mag_b = (nb ? 64'd0 - b_s1 : b_s1) & m_s1;
		wsum  = 8'd0;

		side_c       = '0;
		side_c.width = wa_s1;
		side_c.kind  = bvoe_pkg::KIND_SIMPLE;
		dvd_c        = a_s1;
		dvs_c        = b_s1;

		unique case (bvoe_pkg::opcode_e'(opc_s1))
			bvoe_pkg::OP_NOT: side_c.value = ~a_s1;
			bvoe_pkg::OP_EXTRACT: begin
				if (lo_s1 > hi_s1) begin
					side_c.err   = 1'b1;
					side_c.width = 7'd1;
				end else begin
					side_c.width = {1'b0, hi_s1 - lo_s1} + 7'd1;
					side_c.value = a_s1 >> lo_s1;
				end
			end
			bvoe_pkg::OP_ZEXT, bvoe_pkg::OP_SEXT: begin
				wsum = {1'b0, wa_s1} + {2'b00, hi_s1};
				if (wsum > {1'b0, MAXW}) begin
					side_c.err   = 1'b1;
					side_c.width = 7'd1;
				end else begin
					side_c.width = wsum[6:0];
					side_c.value = (opc_s1 == bvoe_pkg::OP_SEXT && na) ? (a_s1 | ~m_s1) : a_s1;
				end
			end
			bvoe_pkg::OP_NEG:  side_c.value = 64'd0 - a_s1;
			bvoe_pkg::OP_ADD:  side_c.value = a_s1 + b_s1;
			bvoe_pkg::OP_AND:  side_c.value = a_s1 & b_s1;
			bvoe_pkg::OP_CONCAT: begin
				wsum = {1'b0, wa_s1} + {1'b0, wb_s1};
				if (wsum > {1'b0, MAXW}) begin
					side_c.err   = 1'b1;
					side_c.width = 7'd1;
				end else begin
					side_c.width = wsum[6:0];
					side_c.value = (wb_s1 >= 7'd64) ? bb_s1 : ((a_s1 << wb_s1[5:0]) | bb_s1);
				end
			end
			bvoe_pkg::OP_EQUAL, bvoe_pkg::OP_COMP: begin
				side_c.width = 7'd1;
				side_c.value = {63'd0, a_s1 == b_s1};
			end
			bvoe_pkg::OP_XOR: side_c.value = a_s1 ^ b_s1;
			bvoe_pkg::OP_OR:  side_c.value = a_s1 | b_s1;
			bvoe_pkg::OP_MUL: side_c.kind  = bvoe_pkg::KIND_MUL;
			bvoe_pkg::OP_DISTINCT: begin
				side_c.width = 7'd1;
				side_c.value = {63'd0, a_s1 != b_s1};
			end
			bvoe_pkg::OP_UDIV: side_c.kind  = bvoe_pkg::KIND_QUO;
			bvoe_pkg::OP_SUB:  side_c.value = a_s1 - b_s1;
			bvoe_pkg::OP_ULT: begin
				side_c.width = 7'd1;
				side_c.value = {63'd0, a_s1 < b_s1};
			end
			bvoe_pkg::OP_ULE: begin
				side_c.width = 7'd1;
				side_c.value = {63'd0, a_s1 <= b_s1};
			end
			bvoe_pkg::OP_UGT: begin
				side_c.width = 7'd1;
				side_c.value = {63'd0, a_s1 > b_s1};
			end
			bvoe_pkg::OP_UGE: begin
				side_c.width = 7'd1;
				side_c.value = {63'd0, a_s1 >= b_s1};
			end
			bvoe_pkg::OP_SLT: begin
				side_c.width = 7'd1;
				side_c.value = {63'd0, sa < sb};
			end
			bvoe_pkg::OP_SLE: begin
				side_c.width = 7'd1;
				side_c.value = {63'd0, sa <= sb};
			end
			bvoe_pkg::OP_SGT: begin
				side_c.width = 7'd1;
				side_c.value = {63'd0, sa > sb};
			end
			bvoe_pkg::OP_SGE: begin
				side_c.width = 7'd1;
				side_c.value = {63'd0, sa >= sb};
			end
			bvoe_pkg::OP_NAND: side_c.value = ~(a_s1 & b_s1);
			bvoe_pkg::OP_NOR:  side_c.value = ~(a_s1 | b_s1);
			bvoe_pkg::OP_XNOR: side_c.value = ~(a_s1 ^ b_s1);
			bvoe_pkg::OP_UREM: side_c.kind  = bvoe_pkg::KIND_REM;
			bvoe_pkg::OP_SDIV: begin
				side_c.kind = bvoe_pkg::KIND_QUO;
				side_c.neg  = na ^ nb;
				dvd_c       = mag_a;
				dvs_c       = mag_b;
			end
			bvoe_pkg::OP_SREM: begin
				side_c.kind = bvoe_pkg::KIND_REM;
				side_c.neg  = na;
				dvd_c       = mag_a;
				dvs_c       = mag_b;
			end
			bvoe_pkg::OP_LSHR: side_c.value = big ? 64'd0 : (a_s1 >> b_s1[5:0]);
			bvoe_pkg::OP_ASHR: begin
				if (big) begin
					side_c.value = na ? m_s1 : 64'd0;
				end else begin
					side_c.value = (a_s1 >> b_s1[5:0])
						| (na ? (m_s1 & ~(m_s1 >> b_s1[5:0])) : 64'd0);
				end
			end
			bvoe_pkg::OP_SHL:     side_c.value = big ? 64'd0 : (a_s1 << b_s1[5:0]);
			bvoe_pkg::OP_IMPLIES: side_c.value = ~a_s1 | b_s1;
			bvoe_pkg::OP_ITE: begin
				side_c.value = cond_s1 ? a_s1 : bb_s1;
				side_c.width = cond_s1 ? wa_s1 : wb_s1;
			end
			default: begin
				side_c.err   = 1'b1;
				side_c.width = 7'd1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s2  <= side_c;
		dvd_s2   <= dvd_c;
		dvs_s2   <= dvs_c;
		pp_ll_s2 <= a_s1[31:0] * b_s1[31:0];
		pp_lh_s2 <= 32'(a_s1[31:0] * b_s1[63:32]);
		pp_hl_s2 <= 32'(a_s1[63:32] * b_s1[31:0]);
	end

	// ---------------- stage 3: sum the partial products
	logic            vld_s3;
	bvoe_pkg::side_t side_s3;
	logic [63:0]     dvd_s3, dvs_s3;

	bvoe_pkg::side_t mul_side_c;

	// Replace the value with the product for multiplies
	always_comb begin
		mul_side_c = side_s2;
		if (side_s2.kind == bvoe_pkg::KIND_MUL) begin
			mul_side_c.value = pp_ll_s2 + {pp_lh_s2 + pp_hl_s2, 32'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		side_s3 <= mul_side_c;
		dvd_s3  <= dvd_s2;
		dvs_s3  <= dvs_s2;
	end

	// ---------------- divider stages
	logic            div_vld;
	logic [63:0]     div_quo, div_rem;
	bvoe_pkg::side_t div_side;

	bvoe_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (vld_s3),
		.dividend  (dvd_s3),
		.divisor   (dvs_s3),
		.side_in   (side_s3),
		.out_vld   (div_vld),
		.quotient  (div_quo),
		.remainder (div_rem),
		.side_out  (div_side)
	);

	// ---------------- output register: pick source, fix sign, mask
	logic [63:0] pick;
	logic [63:0] fixed;

	always_comb begin
		unique case (div_side.kind)
			bvoe_pkg::KIND_QUO: pick = div_quo;
			bvoe_pkg::KIND_REM: pick = div_rem;
			default:            pick = div_side.value;
		endcase
		fixed = div_side.neg ? (64'd0 - pick) : pick;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		rsp.result_value <= div_side.err ? 64'd0 : (fixed & bvoe_pkg::wmask(div_side.width));
		rsp.result_width <= div_side.width;
		rsp.error_flag   <= div_side.err;
	end

endmodule

// ----- hdl/bvoe_chk.sv -----
// Port-level checker for the bit-vector operation evaluator, with its bind.
`timescale 1ns / 1ps

module bvoe_chk (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            busy,
	input  bvoe_pkg::cmd_t  cmd,
	input  logic            done,
	input  bvoe_pkg::rsp_t  rsp
);

	// Never hold off a command
	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// A command transfer carries known fields
	a_cmd_known: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> !$isunknown(cmd))
		else $error("unknown command fields");

	// Each result traces back to a command transfer a fixed latency earlier
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, bvoe_pkg::LATENCY))
		else $error("result without matching command");

	// Error results carry zero value and unit width
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.error_flag |-> rsp.result_value == 64'd0 && rsp.result_width == 7'd1)
		else $error("malformed error result");

	// Result width in range and no bits above it
	a_width: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.result_width != 7'd0 && rsp.result_width <= 7'd64
			&& (rsp.result_width == 7'd64
				|| (rsp.result_value >> rsp.result_width[5:0]) == 64'd0))
		else $error("result bits beyond width");

endmodule

bind bitvector_operation_evaluator bvoe_chk u_bvoe_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done),
	.rsp    (rsp)
);
